>>> rtl/parametric_surface_vertex_core_assert.svh
`ifndef PARAMETRIC_SURFACE_VERTEX_CORE_ASSERT_SVH
`define PARAMETRIC_SURFACE_VERTEX_CORE_ASSERT_SVH

// same-cycle implication
`define PSV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/psv_pkg.sv
package psv_pkg;

  localparam int COORD_FRAC_BITS = 12;

  localparam int SIN_LAT      = 8;
  localparam int HORNER_STEPS = 5;
  localparam int SIN_LANES    = 6;
  localparam int SQRT_STEPS   = 31;
  localparam int RAD_W        = 61;
  localparam int DIV_STEPS    = 15;
  localparam int NUM_W        = 45;
  localparam int MAG_W        = 28;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int RADIUS_W   = 19;
  localparam int PHASE_W    = 16;

  localparam logic [1:0] MODE_SPHERE = 2'd0;
  localparam logic [1:0] MODE_TORUS  = 2'd1;
  localparam logic [1:0] MODE_WAVE   = 2'd2;
  localparam logic [1:0] MODE_GRID   = 2'd3;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_MAJOR  = 3'd1;
  localparam logic [2:0] REG_MINOR  = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;
  localparam logic [2:0] REG_PHASE  = 3'd5;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  localparam logic signed [31:0] SIN_C11 = 32'sd3864;
  localparam logic signed [31:0] HORNER_C [HORNER_STEPS] = '{
    32'sd172271, 32'sd5026995, 32'sd85569306, 32'sd693598670, 32'sd1686629713
  };
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [31:0] AMP_Q30 = 32'sd214748365;
  localparam logic signed [15:0] NORM_MAX = 16'sd16384;

  typedef struct packed {
    logic [15:0] u_coord;
    logic [15:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } out_item_t;

  // shift right, round half away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] a,
                                              input int unsigned s);
    logic [63:0] m;
    logic [63:0] r;
    m = a[63] ? 64'(-a) : 64'(a);
    if (s == 0) begin
      r = m;
    end else begin
      r = (m + (64'd1 << (s - 1))) >> s;
    end
    return a[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] mulq30(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] r;
    r = rshr(64'(a) * 64'(b), 30);
    return r[31:0];
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [63:0] v);
    logic signed [19:0] r;
    if (v > 64'sd524287) begin
      r = 20'sd524287;
    end else if (v < -64'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] norm14(input logic signed [31:0] v);
    logic signed [63:0] r;
    logic signed [15:0] o;
    r = rshr(64'(v), 16);
    if (r > 64'sd16384) begin
      o = NORM_MAX;
    end else if (r < -64'sd16384) begin
      o = -NORM_MAX;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  function automatic logic signed [63:0] coord_q15(input logic [15:0] c);
    logic signed [63:0] r;
    if (COORD_FRAC_BITS >= 15) begin
      r = $signed(64'(c)) <<< (COORD_FRAC_BITS >= 15 ? COORD_FRAC_BITS - 15 : 0);
    end else begin
      r = rshr($signed(64'(c)), (COORD_FRAC_BITS < 15 ? 15 - COORD_FRAC_BITS : 0));
    end
    return r;
  endfunction

endpackage

>>> rtl/psv_sin.sv
module psv_sin (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        phase,
  output logic signed [31:0] sin_out
);

  logic [30:0]        x_p   [0:psv_pkg::HORNER_STEPS+1];
  logic               neg_p [0:psv_pkg::HORNER_STEPS+1];
  logic [30:0]        x2_p  [1:psv_pkg::HORNER_STEPS+1];
  logic signed [31:0] acc_p [2:psv_pkg::HORNER_STEPS+1];

  logic [14:0] xq;
  logic [61:0] sq;
  logic signed [31:0] acc_c;
  logic [61:0] prodf;
  logic [31:0] s_raw;
  logic signed [31:0] s_lim;

  always_comb begin
    xq = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    sq = 62'(x_p[0]) * 62'(x_p[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_p[0]   <= {xq, 16'b0};
      neg_p[0] <= phase[15];
      x_p[1]   <= x_p[0];
      neg_p[1] <= neg_p[0];
      x2_p[1]  <= sq[60:30];
    end
  end

  for (genvar h = 0; h < psv_pkg::HORNER_STEPS; h++) begin : g_horner
    logic signed [31:0] acc_in;
    logic signed [63:0] prod;
    logic signed [63:0] sh;
    assign acc_in = (h == 0) ? psv_pkg::SIN_C11 : acc_p[(h == 0) ? 2 : h + 1];
    assign prod   = 64'(acc_in) * $signed({33'b0, x2_p[h+1]});
    assign sh     = prod >>> 30;
    always_ff @(posedge clk) begin
      if (en) begin
        x_p[h+2]   <= x_p[h+1];
        neg_p[h+2] <= neg_p[h+1];
        x2_p[h+2]  <= x2_p[h+1];
        acc_p[h+2] <= psv_pkg::HORNER_C[h] - sh[31:0];
      end
    end
  end

  always_comb begin
    acc_c = acc_p[psv_pkg::HORNER_STEPS+1][31] ? 32'sd0 : acc_p[psv_pkg::HORNER_STEPS+1];
    prodf = 62'(x_p[psv_pkg::HORNER_STEPS+1]) * 62'(acc_c[30:0]);
    s_raw = prodf[61:30];
    s_lim = ($signed(s_raw) > psv_pkg::ONE_Q30) ? psv_pkg::ONE_Q30 : $signed(s_raw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_out <= neg_p[psv_pkg::HORNER_STEPS+1] ? -s_lim : s_lim;
    end
  end

endmodule

>>> rtl/psv_sqrt.sv
module psv_sqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [psv_pkg::RAD_W-1:0]        rad,
  output logic [psv_pkg::SQRT_STEPS-1:0]   root
);

  localparam int RW = psv_pkg::RAD_W;
  localparam int QW = psv_pkg::SQRT_STEPS;

  logic [RW-1:0] rem_p [QW];
  logic [QW-1:0] q_p   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [RW+1:0] trial;
    if (k == 0) begin : g_first
      assign rem_in = rad;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_p[k-1];
      assign q_in   = q_p[k-1];
    end
    assign trial = ((RW+2)'(q_in) << (B + 1)) + ((RW+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if ((RW+2)'(rem_in) >= trial) begin
          rem_p[k] <= rem_in - trial[RW-1:0];
          q_p[k]   <= q_in | (QW'(1) << B);
        end else begin
          rem_p[k] <= rem_in;
          q_p[k]   <= q_in;
        end
      end
    end
  end

  assign root = q_p[QW-1];

endmodule

>>> rtl/psv_div.sv
module psv_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [psv_pkg::NUM_W-1:0]       num,
  input  logic [psv_pkg::SQRT_STEPS-1:0]  den,
  output logic [psv_pkg::DIV_STEPS-1:0]   quo
);

  localparam int NW = psv_pkg::NUM_W;
  localparam int DW = psv_pkg::SQRT_STEPS;
  localparam int QW = psv_pkg::DIV_STEPS;

  logic [NW-1:0] rem_p [QW];
  logic [DW-1:0] den_p [QW];
  logic [QW-1:0] q_p   [QW];

  // quotient rounded half up: (num + den/2) / den
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [NW:0]   cmp;
    if (k == 0) begin : g_first
      assign rem_in = num + NW'(den >> 1);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_p[k-1];
      assign den_in = den_p[k-1];
      assign q_in   = q_p[k-1];
    end
    assign cmp = (NW+1)'(den_in) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        den_p[k] <= den_in;
        if ((NW+1)'(rem_in) >= cmp) begin
          rem_p[k] <= rem_in - cmp[NW-1:0];
          q_p[k]   <= q_in | (QW'(1) << B);
        end else begin
          rem_p[k] <= rem_in;
          q_p[k]   <= q_in;
        end
      end
    end
  end

  assign quo = q_p[QW-1];

endmodule

>>> rtl/parametric_surface_vertex_core.sv
// channel   direction  handshake                  payload
// sample    in         sample_valid/sample_ready  u_coord, v_coord
// vertex    out        vertex_valid/vertex_ready  pos_x/y/z, norm_x/y/z
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. Pipeline stages: 8 for
// the sine polynomial lanes, 3 for products and squares, 31 for the
// square-root pipeline, 15 for the divider pipeline, 1 output register.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stalled output freezes every stage; sample_ready drops only then.
module parametric_surface_vertex_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  psv_pkg::in_item_t                  sample,
  output logic                               vertex_valid,
  input  logic                               vertex_ready,
  output psv_pkg::out_item_t                 vertex,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [psv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CFB  = psv_pkg::COORD_FRAC_BITS;
  localparam int NSTG = psv_pkg::SQRT_STEPS + psv_pkg::DIV_STEPS;
  localparam int LAT  = psv_pkg::SIN_LAT + 4 + NSTG;

  typedef struct packed {
    logic signed [19:0] px;
    logic signed [19:0] py;
  } xy_t;

  typedef struct packed {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               sx_neg;
    logic               sy_neg;
    logic [psv_pkg::MAG_W-1:0] sx_mag;
    logic [psv_pkg::MAG_W-1:0] sy_mag;
  } side_t;

  logic [1:0]                     surface_mode;
  logic [psv_pkg::RADIUS_W-1:0]   major_radius;
  logic [psv_pkg::RADIUS_W-1:0]   minor_radius;
  logic [psv_pkg::RADIUS_W-1:0]   plane_width;
  logic [psv_pkg::RADIUS_W-1:0]   plane_height;
  logic [psv_pkg::PHASE_W-1:0]    wave_phase;

  logic en;
  logic [LAT-1:0] vld;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_mode <= psv_pkg::MODE_SPHERE;
      major_radius <= 19'd4096;
      minor_radius <= 19'd2048;
      plane_width  <= 19'd8192;
      plane_height <= 19'd8192;
      wave_phase   <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psv_pkg::REG_MODE:   surface_mode <= cfg_data[1:0];
        psv_pkg::REG_MAJOR:  major_radius <= cfg_data;
        psv_pkg::REG_MINOR:  minor_radius <= cfg_data;
        psv_pkg::REG_WIDTH:  plane_width  <= cfg_data;
        psv_pkg::REG_HEIGHT: plane_height <= cfg_data;
        psv_pkg::REG_PHASE:  wave_phase   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign en           = !vld[LAT-1] || vertex_ready;
  assign sample_ready = en;
  assign vertex_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], sample_valid};
    end
  end

  logic signed [31:0] major_s;
  logic signed [31:0] minor_s;
  assign major_s = $signed({13'b0, major_radius});
  assign minor_s = $signed({13'b0, minor_radius});

  // entry: lane phases and plane coordinates
  logic [15:0] u;
  logic [15:0] v;
  logic [15:0] u2;
  logic [15:0] v2;
  logic [15:0] u5;
  logic [15:0] v5;
  logic [15:0] ph [psv_pkg::SIN_LANES];
  logic signed [31:0] s [psv_pkg::SIN_LANES];
  logic [63:0] uw;
  logic [63:0] vh;
  xy_t xy_in;
  xy_t xy_d [0:psv_pkg::SIN_LAT+1];

  assign u  = sample.u_coord;
  assign v  = sample.v_coord;
  assign u2 = {u[14:0], 1'b0};
  assign v2 = {v[14:0], 1'b0};
  assign u5 = u + {u[13:0], 2'b0};
  assign v5 = v + {v[13:0], 2'b0};
  assign uw = 64'(u) * 64'(plane_width);
  assign vh = 64'(v) * 64'(plane_height);

  always_comb begin
    for (int i = 0; i < psv_pkg::SIN_LANES; i++) ph[i] = '0;
    xy_in = '0;
    unique case (surface_mode)
      psv_pkg::MODE_SPHERE: begin
        ph[0] = v;
        ph[1] = u2 + psv_pkg::QUARTER_TURN;
        ph[2] = u2;
        ph[3] = v + psv_pkg::QUARTER_TURN;
      end
      psv_pkg::MODE_TORUS: begin
        ph[0] = v2 + psv_pkg::QUARTER_TURN;
        ph[1] = u2 + psv_pkg::QUARTER_TURN;
        ph[2] = u2;
        ph[3] = v2;
      end
      psv_pkg::MODE_WAVE: begin
        ph[0] = v5 + wave_phase;
        ph[1] = u5 + wave_phase;
        ph[2] = v5 + psv_pkg::QUARTER_TURN;
        ph[3] = u5;
        ph[4] = v5;
        ph[5] = u5 + psv_pkg::QUARTER_TURN;
        xy_in.px = psv_pkg::sat20(psv_pkg::rshr($signed(uw), 15) - (64'sd1 <<< CFB));
        xy_in.py = psv_pkg::sat20(psv_pkg::rshr($signed(vh), 15) - (64'sd1 <<< CFB));
      end
      psv_pkg::MODE_GRID: begin
        xy_in.px = psv_pkg::sat20(psv_pkg::coord_q15(u));
        xy_in.py = psv_pkg::sat20(psv_pkg::coord_q15(v));
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < psv_pkg::SIN_LANES; g++) begin : g_lane
    psv_sin u_sin (
      .clk     (clk),
      .en      (en),
      .phase   (ph[g]),
      .sin_out (s[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xy_d[0] <= xy_in;
      for (int k = 1; k <= psv_pkg::SIN_LAT + 1; k++) xy_d[k] <= xy_d[k-1];
    end
  end

  // first products
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [31:0] mc;
  logic signed [31:0] s1_r;
  logic signed [31:0] s2_r;
  logic signed [31:0] s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= psv_pkg::mulq30(s[1], s[0]);
      s1_r <= s[1];
      s2_r <= s[2];
      s3_r <= s[3];
      if (surface_mode == psv_pkg::MODE_WAVE) begin
        mb <= psv_pkg::mulq30(s[2], s[3]);
        mc <= psv_pkg::mulq30(s[4], s[5]);
      end else begin
        mb <= psv_pkg::mulq30(s[2], s[0]);
        mc <= psv_pkg::mulq30(minor_s, s[0]);
      end
    end
  end

  // second products
  logic signed [31:0] a01;
  logic signed [31:0] a2;
  logic signed [31:0] b0;
  logic signed [31:0] b1;
  logic signed [31:0] b2;
  logic signed [31:0] p1;
  logic signed [31:0] l0;
  logic signed [31:0] l1;
  logic signed [31:0] l2;
  logic signed [15:0] n_x;
  logic signed [15:0] n_y;
  logic signed [15:0] n_z;

  always_comb begin
    unique case (surface_mode) inside
      psv_pkg::MODE_TORUS: begin
        a01 = major_s + mc;
        b0  = s1_r;
        b1  = s2_r;
        a2  = minor_s;
        b2  = s3_r;
      end
      psv_pkg::MODE_WAVE: begin
        a01 = psv_pkg::AMP_Q30;
        b0  = ma;
        b1  = mb;
        a2  = psv_pkg::AMP_Q30;
        b2  = mc;
      end
      psv_pkg::MODE_SPHERE, psv_pkg::MODE_GRID: begin
        a01 = major_s;
        b0  = ma;
        b1  = mb;
        a2  = major_s;
        b2  = s3_r;
      end
      default: begin
        a01 = major_s;
        b0  = ma;
        b1  = mb;
        a2  = major_s;
        b2  = s3_r;
      end
    endcase
    p1 = psv_pkg::mulq30(a01, b1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0  <= psv_pkg::mulq30(a01, b0);
      l1  <= (surface_mode == psv_pkg::MODE_WAVE) ? -p1 : p1;
      l2  <= psv_pkg::mulq30(a2, b2);
      n_x <= psv_pkg::norm14(ma);
      n_y <= psv_pkg::norm14(mb);
      n_z <= psv_pkg::norm14(s3_r);
    end
  end

  // final positions, slope magnitudes and radicand
  side_t side_in;
  side_t side [0:NSTG];
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [63:0] rad_sum;
  logic [psv_pkg::RAD_W-1:0] rad_r;

  assign ax      = l1[31] ? -l1 : l1;
  assign ay      = l2[31] ? -l2 : l2;
  assign rad_sum = 64'(l1) * 64'(l1) + 64'(l2) * 64'(l2) + (64'sd1 <<< 60);

  always_comb begin
    side_in = '0;
    unique case (surface_mode) inside
      psv_pkg::MODE_SPHERE, psv_pkg::MODE_TORUS: begin
        side_in.px = psv_pkg::sat20(64'(l0));
        side_in.py = psv_pkg::sat20(64'(l1));
        side_in.pz = psv_pkg::sat20(64'(l2));
        side_in.nx = n_x;
        side_in.ny = n_y;
        side_in.nz = n_z;
      end
      psv_pkg::MODE_WAVE: begin
        side_in.px     = xy_d[psv_pkg::SIN_LAT+1].px;
        side_in.py     = xy_d[psv_pkg::SIN_LAT+1].py;
        side_in.pz     = psv_pkg::sat20(psv_pkg::rshr(64'(l0), 30 - CFB));
        side_in.sx_neg = l1[31];
        side_in.sy_neg = l2[31];
        side_in.sx_mag = ax[psv_pkg::MAG_W-1:0];
        side_in.sy_mag = ay[psv_pkg::MAG_W-1:0];
      end
      psv_pkg::MODE_GRID: begin
        side_in.px = xy_d[psv_pkg::SIN_LAT+1].px;
        side_in.py = xy_d[psv_pkg::SIN_LAT+1].py;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      rad_r   <= rad_sum[psv_pkg::RAD_W-1:0];
      for (int k = 1; k <= NSTG; k++) side[k] <= side[k-1];
    end
  end

  // wave normal: components over sqrt(sx^2 + sy^2 + 1)
  logic [psv_pkg::SQRT_STEPS-1:0] root;
  logic [psv_pkg::NUM_W-1:0]      num_x;
  logic [psv_pkg::NUM_W-1:0]      num_y;
  logic [psv_pkg::NUM_W-1:0]      num_z;
  logic [psv_pkg::DIV_STEPS-1:0]  q_x;
  logic [psv_pkg::DIV_STEPS-1:0]  q_y;
  logic [psv_pkg::DIV_STEPS-1:0]  q_z;

  psv_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_r),
    .root (root)
  );

  assign num_x = psv_pkg::NUM_W'({side[psv_pkg::SQRT_STEPS].sx_mag, 14'b0});
  assign num_y = psv_pkg::NUM_W'({side[psv_pkg::SQRT_STEPS].sy_mag, 14'b0});
  assign num_z = psv_pkg::NUM_W'(1) << 44;

  psv_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(root), .quo(q_x));
  psv_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(root), .quo(q_y));
  psv_div u_div_z (.clk(clk), .en(en), .num(num_z), .den(root), .quo(q_z));

  function automatic logic signed [15:0] qnorm(input logic [14:0] q, input logic neg);
    logic signed [15:0] m;
    m = (q > 15'd16384) ? psv_pkg::NORM_MAX : $signed({1'b0, q});
    return neg ? -m : m;
  endfunction

  psv_pkg::out_item_t out_next;

  always_comb begin
    out_next.pos_x = side[NSTG].px;
    out_next.pos_y = side[NSTG].py;
    out_next.pos_z = side[NSTG].pz;
    if (surface_mode == psv_pkg::MODE_WAVE) begin
      out_next.norm_x = qnorm(q_x, side[NSTG].sx_neg);
      out_next.norm_y = qnorm(q_y, side[NSTG].sy_neg);
      out_next.norm_z = qnorm(q_z, 1'b0);
    end else begin
      out_next.norm_x = side[NSTG].nx;
      out_next.norm_y = side[NSTG].ny;
      out_next.norm_z = side[NSTG].nz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vertex <= out_next;
    end
  end

endmodule

>>> rtl/psv_chk.sv
`include "parametric_surface_vertex_core_assert.svh"

module psv_chk (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic               vertex_valid,
  input logic               vertex_ready,
  input psv_pkg::out_item_t vertex
);

  `PSV_ASSERT_NEXT(a_out_hold, clk, rst, vertex_valid && !vertex_ready, vertex_valid && $stable(vertex), "vertex item changed while stalled")

  `PSV_ASSERT_IMPL(a_ready_tie, clk, rst, 1'b1, sample_ready == (!vertex_valid || vertex_ready), "sample_ready not tied to output stall")

  `PSV_ASSERT_IMPL(a_norm_range, clk, rst, vertex_valid, vertex.norm_x >= -16'sd16384 && vertex.norm_x <= 16'sd16384 && vertex.norm_y >= -16'sd16384 && vertex.norm_y <= 16'sd16384 && vertex.norm_z >= -16'sd16384 && vertex.norm_z <= 16'sd16384, "normal out of range")

  `PSV_ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !vertex_valid && !(sample_valid && 1'b0), "vertex item right after reset")

endmodule

bind parametric_surface_vertex_core psv_chk u_psv_chk (.*);

>>> tb/sv/parametric_surface_vertex_core_tb.sv
module parametric_surface_vertex_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 800000;
  localparam int DRAIN_CYCLES = 70;
  localparam int FRAC = psv_pkg::COORD_FRAC_BITS;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic [18:0] RAD_MAX = 19'h7FFFF;
  localparam longint K1 = 1686629713;
  localparam longint K3 = 693598670;
  localparam longint K5 = 85569306;
  localparam longint K7 = 5026995;
  localparam longint K9 = 172271;
  localparam longint K11 = 3864;
  localparam longint Q30_ONE = 1073741824;
  localparam longint Q30_AMP = 214748365;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  psv_pkg::in_item_t sample = '0;
  logic vertex_valid;
  logic vertex_ready = 1'b0;
  psv_pkg::out_item_t vertex;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [psv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [psv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  psv_pkg::in_item_t pending_samples[$];
  psv_pkg::out_item_t expected_vertices[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;

  logic [1:0] cur_mode = psv_pkg::MODE_SPHERE;
  logic [18:0] cur_major = 19'd4096;
  logic [18:0] cur_minor = 19'd2048;
  logic [18:0] cur_width = 19'd8192;
  logic [18:0] cur_height = 19'd8192;
  logic [15:0] cur_phase = 16'd0;

  parametric_surface_vertex_core i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .vertex_valid(vertex_valid), .vertex_ready(vertex_ready), .vertex(vertex),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint round_shift(longint a, int s);
    longint m;
    if (s == 0) return a;
    m = (a < 0) ? -a : a;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (a < 0) ? -m : m;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sine_q30(logic [15:0] p);
    longint x, x2, acc, s;
    x = p[14] ? (16384 - longint'(p[13:0])) : longint'(p[13:0]);
    x = x * 65536;
    x2 = (x * x) >>> 30;
    acc = K11;
    acc = K9 - ((acc * x2) >>> 30);
    acc = K7 - ((acc * x2) >>> 30);
    acc = K5 - ((acc * x2) >>> 30);
    acc = K3 - ((acc * x2) >>> 30);
    acc = K1 - ((acc * x2) >>> 30);
    if (acc < 0) acc = 0;
    s = (x * acc) >>> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    return p[15] ? -s : s;
  endfunction

  function automatic longint cosine_q30(logic [15:0] p);
    return sine_q30(p + psv_pkg::QUARTER_TURN);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint div_near(longint num, longint unsigned den);
    longint unsigned m;
    m = (num < 0) ? longint'(-num) : longint'(num);
    m = (m + den / 2) / den;
    return (num < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic psv_pkg::out_item_t vertex_of(psv_pkg::in_item_t s);
    longint p[3], n[3], n30[3];
    longint sv, cu, su, cv, ring, h30, sx, sy;
    longint unsigned m;
    logic [15:0] a, b;
    psv_pkg::out_item_t r;
    p = '{0, 0, 0};
    n = '{0, 0, 0};
    case (cur_mode)
      psv_pkg::MODE_SPHERE: begin
        a = 16'(2 * s.u_coord);
        sv = sine_q30(s.v_coord);
        n30[0] = mul_q30(cosine_q30(a), sv);
        n30[1] = mul_q30(sine_q30(a), sv);
        n30[2] = cosine_q30(s.v_coord);
        for (int i = 0; i < 3; i++) begin
          n[i] = clip(round_shift(n30[i], 16), -16384, 16384);
          p[i] = mul_q30(longint'(cur_major), n30[i]);
        end
      end
      psv_pkg::MODE_TORUS: begin
        a = 16'(2 * s.u_coord);
        b = 16'(2 * s.v_coord);
        cu = cosine_q30(a);
        su = sine_q30(a);
        cv = cosine_q30(b);
        sv = sine_q30(b);
        ring = longint'(cur_major) + mul_q30(longint'(cur_minor), cv);
        n[0] = clip(round_shift(mul_q30(cu, cv), 16), -16384, 16384);
        n[1] = clip(round_shift(mul_q30(su, cv), 16), -16384, 16384);
        n[2] = clip(round_shift(sv, 16), -16384, 16384);
        p[0] = mul_q30(ring, cu);
        p[1] = mul_q30(ring, su);
        p[2] = mul_q30(longint'(cur_minor), sv);
      end
      psv_pkg::MODE_WAVE: begin
        a = 16'(5 * s.u_coord);
        b = 16'(5 * s.v_coord);
        h30 = mul_q30(mul_q30(sine_q30(b + cur_phase), sine_q30(a + cur_phase)), Q30_AMP);
        sx = -mul_q30(mul_q30(cosine_q30(b), sine_q30(a)), Q30_AMP);
        sy = mul_q30(mul_q30(sine_q30(b), cosine_q30(a)), Q30_AMP);
        m = int_sqrt(longint'(sx * sx) + longint'(sy * sy) + (64'd1 << 60));
        n[0] = clip(div_near(sx * 16384, m), -16384, 16384);
        n[1] = clip(div_near(sy * 16384, m), -16384, 16384);
        n[2] = clip(div_near(Q30_ONE * 16384, m), -16384, 16384);
        p[0] = round_shift(longint'(s.u_coord) * longint'(cur_width), 15) - (64'sd1 <<< FRAC);
        p[1] = round_shift(longint'(s.v_coord) * longint'(cur_height), 15) - (64'sd1 <<< FRAC);
        p[2] = round_shift(h30, 30 - FRAC);
      end
      default: begin
        if (FRAC >= 15) begin
          p[0] = longint'(s.u_coord) <<< (FRAC >= 15 ? FRAC - 15 : 0);
          p[1] = longint'(s.v_coord) <<< (FRAC >= 15 ? FRAC - 15 : 0);
        end else begin
          p[0] = round_shift(longint'(s.u_coord), 15 - FRAC);
          p[1] = round_shift(longint'(s.v_coord), 15 - FRAC);
        end
      end
    endcase
    r.pos_x = 20'(clip(p[0], -524288, 524287));
    r.pos_y = 20'(clip(p[1], -524288, 524287));
    r.pos_z = 20'(clip(p[2], -524288, 524287));
    r.norm_x = 16'(n[0]);
    r.norm_y = 16'(n[1]);
    r.norm_z = 16'(n[2]);
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 85) return $urandom_range(1, 2);
    if (k < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) expected_vertices.push_back(vertex_of(sample));
      if (!sample_valid || sample_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch expected %0d actual %0d", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    psv_pkg::out_item_t e;
    if (rst) begin
      vertex_ready <= 1'b0;
    end else begin
      if (vertex_valid && vertex_ready) begin
        if (expected_vertices.size() == 0) begin
          errors++;
          $display("%0t: unexpected vertex item %h", $time, vertex);
        end else begin
          e = expected_vertices.pop_front();
          check_field("pos_x", e.pos_x, vertex.pos_x);
          check_field("pos_y", e.pos_y, vertex.pos_y);
          check_field("pos_z", e.pos_z, vertex.pos_z);
          check_field("norm_x", e.norm_x, vertex.norm_x);
          check_field("norm_y", e.norm_y, vertex.norm_y);
          check_field("norm_z", e.norm_z, vertex.norm_z);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        vertex_ready <= 1'b0;
      end else begin
        vertex_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("parametric_surface_vertex_core test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [18:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      psv_pkg::REG_MODE: cur_mode = data[1:0];
      psv_pkg::REG_MAJOR: cur_major = data;
      psv_pkg::REG_MINOR: cur_minor = data;
      psv_pkg::REG_WIDTH: cur_width = data;
      psv_pkg::REG_HEIGHT: cur_height = data;
      psv_pkg::REG_PHASE: cur_phase = data[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || sample_valid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [18:0] pick_radius();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 19'd0;
    if (k == 1) return RAD_MAX;
    if (k < 6) return 19'($urandom_range(0, 16384));
    return 19'($urandom);
  endfunction

  function automatic logic [15:0] pick_coord();
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return 16'd0;
    if (k < 6) return 16'd32768;
    if (k < 16) return 16'($urandom);
    return 16'($urandom_range(0, 32768));
  endfunction

  initial begin
    psv_pkg::in_item_t it;
    logic [15:0] corner_u[6];
    logic [15:0] corner_v[6];
    corner_u = '{16'd0, 16'd32768, 16'hFFFF, 16'd16384, 16'd0, 16'd32768};
    corner_v = '{16'd0, 16'd32768, 16'hFFFF, 16'd8192, 16'd32768, 16'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int md = 0; md < 4; md++) begin
      if (md > 0) write_reg(psv_pkg::REG_MODE, 19'(md));
      for (int i = 0; i < 6; i++) begin
        it.u_coord = corner_u[i];
        it.v_coord = corner_v[i];
        pending_samples.push_back(it);
      end
      drain();
    end
    for (int ph = 0; ph < 16; ph++) begin
      quiet = (ph % 5 == 3);
      write_reg(psv_pkg::REG_MODE, (19'($urandom) & 19'h7FFFC) | 19'(ph % 4));
      write_reg(psv_pkg::REG_MAJOR, (ph == 4) ? RAD_MAX : pick_radius());
      write_reg(psv_pkg::REG_MINOR, (ph == 5) ? RAD_MAX : pick_radius());
      write_reg(psv_pkg::REG_WIDTH, (ph == 6) ? RAD_MAX : pick_radius());
      write_reg(psv_pkg::REG_HEIGHT, (ph == 10) ? 19'd0 : pick_radius());
      write_reg(psv_pkg::REG_PHASE, (ph == 6) ? 19'hFFFF : (ph == 2) ? 19'd0 : 19'($urandom));
      if (ph % 4 == 1) write_reg((ph % 8 == 1) ? REG_SPARE_LO : REG_SPARE_HI, 19'($urandom));
      for (int i = 0; i < 97; i++) begin
        it.u_coord = pick_coord();
        it.v_coord = pick_coord();
        pending_samples.push_back(it);
      end
      drain();
    end
    if (errors == 0) begin
      $display("parametric_surface_vertex_core test passed");
    end else begin
      $display("parametric_surface_vertex_core test failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/psv_pkg.sv
rtl/psv_sin.sv
rtl/psv_sqrt.sv
rtl/psv_div.sv
rtl/parametric_surface_vertex_core.sv
rtl/psv_chk.sv
tb/sv/parametric_surface_vertex_core_tb.sv
